// ===== hw/rtl/q7_fir_filter_top_defines.svh =====
// ---------------------------------------------------------------------------
// q7_fir_filter_top_defines.svh
// Assertion helper macros used by the Q7 FIR filter sequencer (qfir_ctrl).
// ---------------------------------------------------------------------------
`ifndef Q7_FIR_FILTER_TOP_DEFINES_SVH
`define Q7_FIR_FILTER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, disabled in reset
`define QFIR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, disabled in reset
`define QFIR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/qfir_pkg.sv =====
// ---------------------------------------------------------------------------
// qfir_pkg
// Shared constants, types and helpers of the Q7 FIR filter.
// ---------------------------------------------------------------------------
`default_nettype none

package qfir_pkg;

  // Sample and tap geometry
  localparam int SAMPLE_W  = 8;
  localparam int MAX_TAPS  = 32;
  localparam int TAP_W     = $clog2(MAX_TAPS);
  localparam int DLY_DEPTH = MAX_TAPS - 1;
  localparam int PROD_W    = 2 * SAMPLE_W;
  // 32 products of at most 2^14 magnitude fit in 21 signed bits
  localparam int ACC_W     = PROD_W + TAP_W;
  localparam int FRAC_W    = 7;
  localparam int SHR_W     = ACC_W - FRAC_W;

  // Configuration port geometry
  localparam int NUM_BANKS  = 4;
  localparam int BANK_W     = 64;
  localparam int COEFF_W    = NUM_BANKS * BANK_W;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 6;
  localparam int REG_IDX_W  = 3;
  localparam int NTAPS_W    = 6;

  // Register indexes
  localparam logic [REG_IDX_W-1:0] REG_NUM_TAPS = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_COEFF_0  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_COEFF_1  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_COEFF_2  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_COEFF_3  = 3'd4;

  // Saturation bounds
  localparam logic signed [SHR_W-1:0] SAT_MAX = SHR_W'(127);
  localparam logic signed [SHR_W-1:0] SAT_MIN = -SHR_W'(128);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_FIN
  } qfir_state_t;

  // Controller to datapath
  typedef struct packed {
    logic             load;
    logic             mac;
    logic             fin;
    logic [TAP_W-1:0] tap;
  } qfir_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
  } qfir_sts_t;

  // Pick one signed coefficient byte out of the flat bank vector
  function automatic logic signed [SAMPLE_W-1:0] coeff_at(
    input logic [COEFF_W-1:0] flat,
    input logic [TAP_W-1:0]   idx
  );
    return flat[{idx, 3'b000} +: SAMPLE_W];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/qfir_if.sv =====
// ---------------------------------------------------------------------------
// qfir_if
// Valid/ready stream interfaces for the sample input and result channels.
// ---------------------------------------------------------------------------
`default_nettype none

interface qfir_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [qfir_pkg::SAMPLE_W-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface qfir_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [qfir_pkg::SAMPLE_W-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/qfir_regs.sv =====
// ---------------------------------------------------------------------------
// qfir_regs
// APB register file: tap count and four coefficient banks.
// ---------------------------------------------------------------------------
`default_nettype none

module qfir_regs (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [qfir_pkg::CFG_ADDR_W-1:0]     paddr,
  input  wire logic [qfir_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic      [qfir_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                     pready,
  output logic      [qfir_pkg::COEFF_W-1:0]        coeff_flat,
  output logic      [qfir_pkg::TAP_W-1:0]          last_tap
);

  logic [qfir_pkg::NTAPS_W-1:0]   num_taps_r, num_taps_nxt;
  logic [qfir_pkg::BANK_W-1:0]    bank_r   [qfir_pkg::NUM_BANKS];
  logic [qfir_pkg::BANK_W-1:0]    bank_nxt [qfir_pkg::NUM_BANKS];
  logic [qfir_pkg::REG_IDX_W-1:0] reg_idx;
  logic                           wr_en;

  // Registers sit on 8-byte boundaries
  assign reg_idx = paddr[qfir_pkg::CFG_ADDR_W-1:3];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // Decode writes; unknown indexes drop the word
  always_comb begin
    num_taps_nxt = num_taps_r;
    for (int b = 0; b < qfir_pkg::NUM_BANKS; b++) begin
      bank_nxt[b] = bank_r[b];
    end
    if (wr_en) begin
      unique case (reg_idx)
        qfir_pkg::REG_NUM_TAPS: num_taps_nxt = pwdata[qfir_pkg::NTAPS_W-1:0];
        qfir_pkg::REG_COEFF_0:  bank_nxt[0]  = pwdata;
        qfir_pkg::REG_COEFF_1:  bank_nxt[1]  = pwdata;
        qfir_pkg::REG_COEFF_2:  bank_nxt[2]  = pwdata;
        qfir_pkg::REG_COEFF_3:  bank_nxt[3]  = pwdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_taps_r <= qfir_pkg::NTAPS_W'(1);
      for (int b = 0; b < qfir_pkg::NUM_BANKS; b++) begin
        bank_r[b] <= '0;
      end
    end else begin
      num_taps_r <= num_taps_nxt;
      for (int b = 0; b < qfir_pkg::NUM_BANKS; b++) begin
        bank_r[b] <= bank_nxt[b];
      end
    end
  end

  // Read-back mux
  always_comb begin
    unique case (reg_idx)
      qfir_pkg::REG_NUM_TAPS: prdata = qfir_pkg::CFG_DATA_W'(num_taps_r);
      qfir_pkg::REG_COEFF_0:  prdata = bank_r[0];
      qfir_pkg::REG_COEFF_1:  prdata = bank_r[1];
      qfir_pkg::REG_COEFF_2:  prdata = bank_r[2];
      qfir_pkg::REG_COEFF_3:  prdata = bank_r[3];
      default:                prdata = '0;
    endcase
  end

  assign coeff_flat = {bank_r[3], bank_r[2], bank_r[1], bank_r[0]};

  // Index of the last tap in use: zero acts as one tap, above the max clamps
  always_comb begin
    if (num_taps_r == '0) begin
      last_tap = '0;
    end else if (num_taps_r >= qfir_pkg::NTAPS_W'(qfir_pkg::MAX_TAPS)) begin
      last_tap = qfir_pkg::TAP_W'(qfir_pkg::MAX_TAPS - 1);
    end else begin
      last_tap = qfir_pkg::TAP_W'(num_taps_r - qfir_pkg::NTAPS_W'(1));
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/qfir_ctrl.sv =====
// ---------------------------------------------------------------------------
// qfir_ctrl
// Sequencer: accepts a word, steps the shared MAC over the taps, retires.
// ---------------------------------------------------------------------------
`default_nettype none

`include "q7_fir_filter_top_defines.svh"

module qfir_ctrl (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [qfir_pkg::TAP_W-1:0]   last_tap,
  input  wire qfir_pkg::qfir_sts_t          sts,
  output qfir_pkg::qfir_cmd_t               cmd
);

  qfir_pkg::qfir_state_t        state_r, state_nxt;
  logic [qfir_pkg::TAP_W-1:0]   tap_r, tap_nxt;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      qfir_pkg::ST_IDLE: if (in_valid) state_nxt = qfir_pkg::ST_MAC;
      qfir_pkg::ST_MAC:  if (tap_r == last_tap) state_nxt = qfir_pkg::ST_FIN;
      qfir_pkg::ST_FIN:  if (sts.out_free) state_nxt = qfir_pkg::ST_IDLE;
      default:           state_nxt = qfir_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    cmd.tap  = tap_r;
    unique case (state_r)
      qfir_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      qfir_pkg::ST_MAC: begin
        cmd.mac = 1'b1;
      end
      qfir_pkg::ST_FIN: begin
        cmd.fin = sts.out_free;
      end
      default: ;
    endcase
  end

  // Tap counter: clear on accept, advance per MAC step
  always_comb begin
    tap_nxt = tap_r;
    if (cmd.load) begin
      tap_nxt = '0;
    end else if (cmd.mac) begin
      tap_nxt = tap_r + qfir_pkg::TAP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= qfir_pkg::ST_IDLE;
      tap_r   <= '0;
    end else begin
      state_r <= state_nxt;
      tap_r   <= tap_nxt;
    end
  end

  `QFIR_ASSERT_NEXT(a_accept_starts_mac, in_valid && in_ready, state_r == qfir_pkg::ST_MAC, "accepted word did not start the MAC sweep")
  `QFIR_ASSERT_NOW(a_tap_in_range, state_r == qfir_pkg::ST_MAC, tap_r <= last_tap, "tap counter ran past the last tap")
  `QFIR_ASSERT_NOW(a_fin_needs_room, cmd.fin, sts.out_free, "result retired into a full output register")
  `QFIR_ASSERT_NEXT(a_fin_returns_idle, cmd.fin, in_ready, "block did not reopen the input after retiring")

endmodule

`default_nettype wire

// ===== hw/rtl/qfir_datapath.sv =====
// ---------------------------------------------------------------------------
// qfir_datapath
// Delay line, shared 8x8 MAC, shift/saturate and the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module qfir_datapath (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire qfir_pkg::qfir_cmd_t                 cmd,
  input  wire logic [qfir_pkg::COEFF_W-1:0]        coeff_flat,
  input  wire logic [qfir_pkg::TAP_W-1:0]          last_tap,
  input  wire logic signed [qfir_pkg::SAMPLE_W-1:0] sample_in,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [qfir_pkg::SAMPLE_W-1:0]     sample_out,
  output qfir_pkg::qfir_sts_t                      sts
);

  logic signed [qfir_pkg::SAMPLE_W-1:0] x_r;
  logic signed [qfir_pkg::SAMPLE_W-1:0] dly_r [qfir_pkg::DLY_DEPTH];
  logic signed [qfir_pkg::ACC_W-1:0]    acc_r, acc_nxt;
  logic signed [qfir_pkg::SAMPLE_W-1:0] out_sample_r;
  logic                                 out_valid_r;

  logic signed [qfir_pkg::SAMPLE_W-1:0] mac_sample;
  logic signed [qfir_pkg::SAMPLE_W-1:0] mac_coeff;
  logic signed [qfir_pkg::PROD_W-1:0]   prod;
  logic        [qfir_pkg::TAP_W-1:0]    dly_idx;
  logic        [qfir_pkg::TAP_W-1:0]    coeff_idx;
  logic signed [qfir_pkg::SHR_W-1:0]    shr;
  logic signed [qfir_pkg::SAMPLE_W-1:0] sat;

  // Tap 0 is the new word, tap j the word j steps back; coefficients reversed
  assign dly_idx    = cmd.tap - qfir_pkg::TAP_W'(1);
  assign mac_sample = (cmd.tap == '0) ? x_r : dly_r[dly_idx];
  assign coeff_idx  = last_tap - cmd.tap;
  assign mac_coeff  = qfir_pkg::coeff_at(coeff_flat, coeff_idx);
  assign prod       = mac_sample * mac_coeff;

  always_comb begin
    acc_nxt = acc_r;
    if (cmd.load) begin
      acc_nxt = '0;
    end else if (cmd.mac) begin
      acc_nxt = acc_r + qfir_pkg::ACC_W'(prod);
    end
  end

  // Floor shift by the fraction width, then clamp to the byte range
  assign shr = qfir_pkg::SHR_W'(acc_r >>> qfir_pkg::FRAC_W);
  always_comb begin
    if (shr > qfir_pkg::SAT_MAX) begin
      sat = qfir_pkg::SAMPLE_W'(qfir_pkg::SAT_MAX);
    end else if (shr < qfir_pkg::SAT_MIN) begin
      sat = qfir_pkg::SAMPLE_W'(qfir_pkg::SAT_MIN);
    end else begin
      sat = shr[qfir_pkg::SAMPLE_W-1:0];
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    if (cmd.load) begin
      x_r <= sample_in;
    end
    if (cmd.fin) begin
      out_sample_r <= sat;
    end
  end

  // Delay line: shift the retired word in, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < qfir_pkg::DLY_DEPTH; i++) begin
        dly_r[i] <= '0;
      end
    end else if (cmd.fin) begin
      dly_r[0] <= x_r;
      for (int i = 1; i < qfir_pkg::DLY_DEPTH; i++) begin
        dly_r[i] <= dly_r[i-1];
      end
    end
  end

  // Output register: set on retire, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.fin) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid    = out_valid_r;
  assign sample_out   = out_sample_r;
  assign sts.out_free = !out_valid_r || out_ready;

endmodule

`default_nettype wire

// ===== hw/rtl/q7_fir_filter_top.sv =====
// ---------------------------------------------------------------------------
// q7_fir_filter_top
// Q7 saturating FIR filter, up to 32 taps, one shared multiply-accumulate.
//
//   channel   dir   handshake         word / access
//   in_ch     in    valid/ready       sample_in, signed Q7 byte
//   out_ch    out   valid/ready       sample_out, signed Q7 byte
//   cfg       in    APB psel/penable  64-bit registers at 8-byte steps
//
// An item passes through the accept cycle, one MAC step per tap in use (1..32) on
// the single 8x8 multiplier, then the retire cycle.
// The result enters the output register at the end of the retire cycle.
// A new word can be taken in the cycle after the previous one retires.
// The output register holds a result while out_ch stalls; the next word is
// still accepted and computed, and waits in its retire cycle until room opens.
// Reset (rst_n, synchronous, active low) clears the delay line, the coefficient banks and
// the output valid flag, and sets the tap count to one.
`default_nettype none

module q7_fir_filter_top (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  qfir_in_if.sink                              in_ch,
  qfir_out_if.source                           out_ch,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [qfir_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [qfir_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [qfir_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                 pready
);

  logic [qfir_pkg::COEFF_W-1:0] coeff_flat;
  logic [qfir_pkg::TAP_W-1:0]   last_tap;
  qfir_pkg::qfir_cmd_t          cmd;
  qfir_pkg::qfir_sts_t          sts;

  // Configuration registers
  qfir_regs u_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .coeff_flat (coeff_flat),
    .last_tap   (last_tap)
  );

  // Sequencer
  qfir_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .last_tap (last_tap),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath
  qfir_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .coeff_flat (coeff_flat),
    .last_tap   (last_tap),
    .sample_in  (in_ch.sample_in),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .sample_out (out_ch.sample_out),
    .sts        (sts)
  );

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Q7 saturating FIR filter. A directed table
// covers reset state, extreme samples and coefficients, floor rounding,
// saturation, out-of-range tap counts, spare register writes and tap count
// changes mid-stream; random phases with random settings follow. Every
// accepted sample is run through a local filter model and each output word is
// checked in order against it or the row's fixed value. Both stream sides idle at random.
// ---------------------------------------------------------------------------

module tb_top;
  import qfir_pkg::*;

  typedef logic signed [SAMPLE_W-1:0] q7_t;

  typedef enum logic {
    ROW_WRITE,
    ROW_SAMPLE
  } row_kind_t;

  typedef struct {
    row_kind_t                kind;
    logic [REG_IDX_W-1:0]     reg_idx;
    logic [CFG_DATA_W-1:0]    value;
    q7_t                      sample;
    bit                       fixed;
    q7_t                      want;
  } stim_row_t;

  // Register indexes that decode to nothing
  localparam logic [REG_IDX_W-1:0] REG_SPARE_0 = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_SPARE_1 = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_SPARE_2 = 3'd7;

  localparam logic [BANK_W-1:0] BANK_ALL_MAX = {8{8'h7F}};
  localparam logic [BANK_W-1:0] BANK_ALL_MIN = {8{8'h80}};

  localparam int RANDOM_ITEMS  = 1100;
  localparam int HOLD_AT       = 300;
  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_CYCLES  = 3 * (MAX_TAPS + 2);

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  qfir_in_if  in_if ();
  qfir_out_if out_if ();

  q7_fir_filter_top u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_if),
    .out_ch  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Local filter state and settings
  q7_t                 history [DLY_DEPTH];
  logic [NTAPS_W-1:0]  tap_reg;
  logic [BANK_W-1:0]   banks [NUM_BANKS];

  q7_t       pending_outputs [$];
  stim_row_t directed_rows [$];
  int        fail_count;
  int        samples_sent;
  int        results_seen;
  int        calm_in;
  int        calm_out;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("tb_top: errors");
    $finish;
  end

  // Gap before the next word: mostly random, sometimes a run of back-to-back words
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(10, 60);
      return 0;
    end
    return $urandom_range(0, 18);
  endfunction

  function automatic q7_t coeff_of(int idx);
    return banks[idx / 8][8 * (idx % 8) +: 8];
  endfunction

  // Filter one sample and advance the delay line
  function automatic q7_t filter_sample(q7_t x);
    int n;
    int acc;
    n = tap_reg;
    if (n == 0) n = 1;
    if (n > MAX_TAPS) n = MAX_TAPS;
    acc = int'(x) * int'(coeff_of(n - 1));
    for (int j = 1; j < n; j++) begin
      acc += int'(history[j - 1]) * int'(coeff_of(n - 1 - j));
    end
    acc = acc >>> FRAC_W;
    if (acc > 127) acc = 127;
    if (acc < -128) acc = -128;
    for (int i = DLY_DEPTH - 1; i > 0; i--) begin
      history[i] = history[i - 1];
    end
    history[0] = x;
    return q7_t'(acc);
  endfunction

  // Write one register once the block has drained
  task automatic cfg_write(logic [REG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    in_if.valid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_NUM_TAPS: tap_reg  = val[NTAPS_W-1:0];
      REG_COEFF_0:  banks[0] = val;
      REG_COEFF_1:  banks[1] = val;
      REG_COEFF_2:  banks[2] = val;
      REG_COEFF_3:  banks[3] = val;
      default: ;
    endcase
  endtask

  // Offer one word; valid stays high on return
  task automatic send_sample(q7_t x, bit fixed, q7_t want);
    int gap;
    q7_t predicted;
    gap = draw_wait(calm_in);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.sample_in <= x;
    do @(posedge clk); while (!in_if.ready);
    predicted = filter_sample(x);
    pending_outputs.push_back(fixed ? want : predicted);
    samples_sent++;
  endtask

  // Stimulus
  initial begin
    int   taps_pick;
    int   phase_len;
    logic [BANK_W-1:0] bank_val;
    q7_t  x;

    rst_n           <= 1'b0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    in_if.valid     <= 1'b0;
    in_if.sample_in <= '0;
    fail_count   = 0;
    samples_sent = 0;
    calm_in      = 0;
    tap_reg      = 1;
    foreach (banks[i]) banks[i] = '0;
    foreach (history[i]) history[i] = '0;

    // Zero coefficients after reset give zero output
    directed_rows.push_back('{ROW_SAMPLE, REG_NUM_TAPS, 64'd0, 8'h7F, 1'b1, 8'h00});
    directed_rows.push_back('{ROW_SAMPLE, REG_NUM_TAPS, 64'd0, 8'h80, 1'b1, 8'h00});
    // Single tap, largest coefficient; floor rounding on negative products
    directed_rows.push_back('{ROW_WRITE, REG_NUM_TAPS, 64'd1, 8'h00, 1'b0, 8'h00});
    directed_rows.push_back('{ROW_WRITE, REG_COEFF_0, 64'h7F, 8'h00, 1'b0, 8'h00});
    directed_rows.push_back('{ROW_SAMPLE, REG_NUM_TAPS, 64'd0, 8'h7F, 1'b1, 8'd126});
    directed_rows.push_back('{ROW_SAMPLE, REG_NUM_TAPS, 64'd0, 8'h01, 1'b1, 8'h00});
    directed_rows.push_back('{ROW_SAMPLE, REG_NUM_TAPS, 64'd0, 8'hFF, 1'b1, 8'hFF});
    // Most negative coefficient: positive saturation on -128 * -128
    directed_rows.push_back('{ROW_WRITE, REG_COEFF_0, 64'h80, 8'h00, 1'b0, 8'h00});
    directed_rows.push_back('{ROW_SAMPLE, REG_NUM_TAPS, 64'd0, 8'h80, 1'b1, 8'h7F});
    directed_rows.push_back('{ROW_SAMPLE, REG_NUM_TAPS, 64'd0, 8'h7F, 1'b1, 8'h81});
    directed_rows.push_back('{ROW_SAMPLE, REG_NUM_TAPS, 64'd0, 8'h00, 1'b1, 8'h00});
    // Zero taps behaves as one tap
    directed_rows.push_back('{ROW_WRITE, REG_NUM_TAPS, 64'd0, 8'h00, 1'b0, 8'h00});
    directed_rows.push_back('{ROW_SAMPLE, REG_NUM_TAPS, 64'd0, 8'h80, 1'b1, 8'h7F});
    // All coefficients at maximum, tap count above the limit
    directed_rows.push_back('{ROW_WRITE, REG_COEFF_0, BANK_ALL_MAX, 8'h00, 1'b0, 8'h00});
    directed_rows.push_back('{ROW_WRITE, REG_COEFF_1, BANK_ALL_MAX, 8'h00, 1'b0, 8'h00});
    directed_rows.push_back('{ROW_WRITE, REG_COEFF_2, BANK_ALL_MAX, 8'h00, 1'b0, 8'h00});
    directed_rows.push_back('{ROW_WRITE, REG_COEFF_3, BANK_ALL_MAX, 8'h00, 1'b0, 8'h00});
    directed_rows.push_back('{ROW_WRITE, REG_NUM_TAPS, 64'd63, 8'h00, 1'b0, 8'h00});
    repeat (4) directed_rows.push_back('{ROW_SAMPLE, REG_NUM_TAPS, 64'd0, 8'h7F, 1'b0, 8'h00});
    repeat (3) directed_rows.push_back('{ROW_SAMPLE, REG_NUM_TAPS, 64'd0, 8'h80, 1'b0, 8'h00});
    // Full 32 taps with the newest coefficients at minimum
    directed_rows.push_back('{ROW_WRITE, REG_NUM_TAPS, 64'd32, 8'h00, 1'b0, 8'h00});
    directed_rows.push_back('{ROW_WRITE, REG_COEFF_3, BANK_ALL_MIN, 8'h00, 1'b0, 8'h00});
    directed_rows.push_back('{ROW_SAMPLE, REG_NUM_TAPS, 64'd0, 8'h7F, 1'b0, 8'h00});
    directed_rows.push_back('{ROW_SAMPLE, REG_NUM_TAPS, 64'd0, 8'h80, 1'b0, 8'h00});
    // Spare register indexes must leave the settings alone
    directed_rows.push_back('{ROW_WRITE, REG_SPARE_0, '1, 8'h00, 1'b0, 8'h00});
    directed_rows.push_back('{ROW_WRITE, REG_SPARE_1, '1, 8'h00, 1'b0, 8'h00});
    directed_rows.push_back('{ROW_WRITE, REG_SPARE_2, '1, 8'h00, 1'b0, 8'h00});
    directed_rows.push_back('{ROW_SAMPLE, REG_NUM_TAPS, 64'd0, 8'h7F, 1'b0, 8'h00});
    // Shrink taps mid-stream (upper bits ignored), then grow back onto old history
    directed_rows.push_back('{ROW_WRITE, REG_NUM_TAPS, 64'hFFFF_FFFF_FFFF_FFC4, 8'h00,
                              1'b0, 8'h00});
    directed_rows.push_back('{ROW_SAMPLE, REG_NUM_TAPS, 64'd0, 8'd55, 1'b0, 8'h00});
    directed_rows.push_back('{ROW_SAMPLE, REG_NUM_TAPS, 64'd0, 8'hB3, 1'b0, 8'h00});
    directed_rows.push_back('{ROW_WRITE, REG_NUM_TAPS, 64'd32, 8'h00, 1'b0, 8'h00});
    directed_rows.push_back('{ROW_WRITE, REG_COEFF_0, 64'hA5A5_5A5A_0123_4567, 8'h00,
                              1'b0, 8'h00});
    directed_rows.push_back('{ROW_SAMPLE, REG_NUM_TAPS, 64'd0, 8'h01, 1'b0, 8'h00});

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        cfg_write(directed_rows[i].reg_idx, directed_rows[i].value);
      end else begin
        send_sample(directed_rows[i].sample, directed_rows[i].fixed, directed_rows[i].want);
      end
    end

    // Random phases: new settings, then a run of samples
    samples_sent = 0;
    while (samples_sent < RANDOM_ITEMS) begin
      taps_pick = $urandom_range(0, 9);
      case (taps_pick)
        0:       cfg_write(REG_NUM_TAPS, 64'd0);
        1:       cfg_write(REG_NUM_TAPS, 64'd63);
        2:       cfg_write(REG_NUM_TAPS, 64'd32);
        3:       cfg_write(REG_NUM_TAPS, 64'd1);
        4:       cfg_write(REG_NUM_TAPS, 64'($urandom_range(33, 62)));
        5:       cfg_write(REG_NUM_TAPS, 64'($urandom_range(1, 31)));
        default: cfg_write(REG_NUM_TAPS, 64'($urandom_range(1, 8)));
      endcase
      for (int b = 0; b < NUM_BANKS; b++) begin
        if ($urandom_range(0, 1) == 1) begin
          case ($urandom_range(0, 5))
            0: bank_val = '0;
            1: bank_val = BANK_ALL_MAX;
            2: bank_val = BANK_ALL_MIN;
            3: bank_val = {$urandom(), $urandom()};
            default: begin
              for (int k = 0; k < 8; k++) begin
                bank_val[8 * k +: 8] = 8'($urandom_range(0, 32)) - 8'd16;
              end
            end
          endcase
          cfg_write(REG_COEFF_0 + 3'(b), bank_val);
        end
      end
      phase_len = $urandom_range(20, 120);
      repeat (phase_len) begin
        if ($urandom_range(0, 4) == 0) begin
          case ($urandom_range(0, 3))
            0: x = 8'h7F;
            1: x = 8'h80;
            2: x = 8'h00;
            default: x = 8'hFF;
          endcase
        end else begin
          x = q7_t'($urandom_range(0, 255));
        end
        send_sample(x, 1'b0, 8'h00);
      end
    end

    // Drain, let the pipeline settle, report
    in_if.valid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // Result side: random stalls, one long hold-off, in-order check
  initial begin
    int  stall;
    q7_t want;
    out_if.ready <= 1'b0;
    results_seen = 0;
    calm_out     = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = draw_wait(calm_out);
      if (results_seen == HOLD_AT) stall = HOLD_CYCLES;
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
      results_seen++;
      if (pending_outputs.size() == 0) begin
        $error("sample_out: word with no expectation, actual %0d", out_if.sample_out);
        fail_count++;
      end else begin
        want = pending_outputs.pop_front();
        if (out_if.sample_out !== want) begin
          $error("sample_out mismatch: expected %0d, actual %0d", want, out_if.sample_out);
          fail_count++;
        end
      end
    end
  end

endmodule
